### src/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants for the linear blend skinning core.
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int WORDS_PER_BONE = 12;
	localparam int WEIGHT_W       = 17;
	localparam int WEIGHT_FRAC    = 16;
	localparam int IDX_W          = 6;
	localparam int MAX_INFL       = 4;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_SKIN  = 1'b1
	} req_t;

	typedef logic signed [31:0] word_t;

	function automatic word_t sat32(input logic signed [71:0] v);
		word_t r;
		if (v > 72'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -72'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### src/lbs_palette.sv
// ----------------------------------------------------------------------------
// lbs_palette
// Bone matrix palette: one bank per influence port and matrix element, written
// one word at a time and read for a whole matrix per influence in parallel.
// ----------------------------------------------------------------------------
module lbs_palette #(
	parameter int NUM_BONES  = 64,
	parameter int INFLUENCES = 4
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((NUM_BONES > 1) ? $clog2(NUM_BONES) : 1)-1:0] wr_bone,
	input  logic [3:0]                               wr_elem,
	input  lbs_pkg::word_t                           wr_data,
	input  logic [INFLUENCES-1:0][((NUM_BONES > 1) ? $clog2(NUM_BONES) : 1)-1:0] rd_bone,
	output lbs_pkg::word_t                           rd_data [INFLUENCES][lbs_pkg::WORDS_PER_BONE]
);

	localparam int BW = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;

	// one memory per (influence port, element); copies keep each array at
	// one write port and one read port
	for (genvar i = 0; i < INFLUENCES; i++) begin : g_port
		for (genvar e = 0; e < lbs_pkg::WORDS_PER_BONE; e++) begin : g_elem
			lbs_pkg::word_t mem [NUM_BONES];
			always_ff @(posedge clk) begin
				if (wr_en && wr_elem == 4'(e)) begin
					mem[wr_bone[BW-1:0]] <= wr_data;
				end
				rd_data[i][e] <= mem[rd_bone[i][BW-1:0]];
			end
		end
	end

endmodule

### src/linear_blend_skinning_core.sv
// ----------------------------------------------------------------------------
// linear_blend_skinning_core
// Accepted vertices pass the blend/transform pipeline, then an output FIFO;
// one transaction per cycle sustained while in_stall is low, set by the
// fully pipelined blend/transform datapath. Palette writes produce no output.
// Reset clears valids and FIFO counts/pointers; palette undefined until written.
// ----------------------------------------------------------------------------
module linear_blend_skinning_core #(
	parameter int NUM_BONES  = 64,
	parameter int INFLUENCES = 4,
	parameter int FRAC_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [23:0]        bone_indices,
	input  logic [33:0]        weights_low_pair,
	input  logic [33:0]        weights_high_pair,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] nrm_x,
	input  logic signed [31:0] nrm_y,
	input  logic signed [31:0] nrm_z,
	input  logic [9:0]         palette_addr,
	input  logic signed [31:0] palette_word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_pos_z,
	output logic signed [31:0] out_nrm_x,
	output logic signed [31:0] out_nrm_y,
	output logic signed [31:0] out_nrm_z
);

	localparam int WPB = lbs_pkg::WORDS_PER_BONE;
	localparam int BW  = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
	localparam int NI  = INFLUENCES;
	localparam int DEPTH = 8;
	localparam int LAT   = 6;

	// ---------------- skid FIFO and credit ----------------
	logic [$clog2(DEPTH+1)-1:0] cnt_q;
	logic [$clog2(DEPTH+1)-1:0] inflight_q;
	logic adv;
	logic acc_in, skin_in, out_fire;
	logic [LAT-1:0] vld_q;
	logic signed [31:0] fifo_q [DEPTH][6];
	logic [$clog2(DEPTH)-1:0] wp_q, rp_q;

	assign adv      = 1'b1;
	assign in_stall = (32'(inflight_q) + 32'(cnt_q)) >= DEPTH;
	assign acc_in   = in_valid && !in_stall;
	assign skin_in  = acc_in && (req_type == lbs_pkg::REQ_SKIN);
	assign out_valid = cnt_q != '0;
	assign out_fire = out_valid && !out_stall;

	// ---------------- decode and palette ----------------
	logic wr_ok;
	logic [9:0] bone_full;
	logic [3:0] elem;
	logic [NI-1:0][BW-1:0] rd_bone;
	logic [NI-1:0] in_rng;

	// divide by 12 via reciprocal, exact for every 10-bit address
	assign bone_full = 10'((20'(palette_addr) * 20'd683) >> 13);
	assign elem      = 4'(palette_addr - bone_full * 10'd12);
	assign wr_ok     = acc_in && (req_type == lbs_pkg::REQ_WRITE)
		&& (32'(palette_addr) < NUM_BONES * WPB);

	always_comb begin
		for (int i = 0; i < NI; i++) begin
			rd_bone[i] = BW'(bone_indices[6*i +: 6]);
			in_rng[i]  = 32'(bone_indices[6*i +: 6]) < NUM_BONES;
		end
	end

	lbs_pkg::word_t mat [NI][WPB];

	lbs_palette #(.NUM_BONES(NUM_BONES), .INFLUENCES(NI)) u_pal (
		.clk     (clk),
		.wr_en   (wr_ok),
		.wr_bone (BW'(bone_full)),
		.wr_elem (elem),
		.wr_data (palette_word),
		.rd_bone (rd_bone),
		.rd_data (mat)
	);

	// stage 1: weights and vectors aligned with palette read
	logic [NI-1:0][16:0] w_s1;
	logic [NI-1:0] rng_s1;
	logic signed [31:0] v_s1 [6];
	logic signed [31:0] v_s2 [6];
	logic signed [31:0] v_s3 [6];

	always_ff @(posedge clk) begin
		for (int i = 0; i < NI; i++) begin
			case (i)
				0: w_s1[i] <= in_rng[i] ? weights_low_pair[16:0]  : '0;
				1: w_s1[i] <= in_rng[i] ? weights_low_pair[33:17] : '0;
				2: w_s1[i] <= in_rng[i] ? weights_high_pair[16:0] : '0;
				default: w_s1[i] <= in_rng[i] ? weights_high_pair[33:17] : '0;
			endcase
		end
		rng_s1 <= in_rng;
		v_s1[0] <= pos_x; v_s1[1] <= pos_y; v_s1[2] <= pos_z;
		v_s1[3] <= nrm_x; v_s1[4] <= nrm_y; v_s1[5] <= nrm_z;
		v_s2 <= v_s1;
		v_s3 <= v_s2;
	end

	// stage 2: weighted products; an out-of-range bone contributes nothing
	logic signed [49:0] prod_s2 [NI][WPB];
	always_ff @(posedge clk) begin
		for (int i = 0; i < NI; i++) begin
			for (int e = 0; e < WPB; e++) begin
				prod_s2[i][e] <= rng_s1[i] ? mat[i][e] * $signed({1'b0, w_s1[i]}) : 50'sd0;
			end
		end
	end

	// stage 3: blend, round, saturate
	lbs_pkg::word_t m_s3 [WPB];
	always_ff @(posedge clk) begin
		for (int e = 0; e < WPB; e++) begin
			logic signed [71:0] acc;
			acc = 72'sd32768;
			for (int i = 0; i < NI; i++) begin
				acc = acc + 72'(prod_s2[i][e]);
			end
			m_s3[e] <= lbs_pkg::sat32(acc >>> lbs_pkg::WEIGHT_FRAC);
		end
	end

	// stage 4: row products
	logic signed [63:0] tp_s4 [3][6];
	logic signed [31:0] tr_s4 [3];
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			tr_s4[r] <= m_s3[4*r+3];
			for (int k = 0; k < 3; k++) begin
				tp_s4[r][k]   <= m_s3[4*r+k] * v_s3[k];
				tp_s4[r][3+k] <= m_s3[4*r+k] * v_s3[3+k];
			end
		end
	end

	// stage 5: sums (floor of exact total equals the split form)
	logic signed [71:0] sum_s5 [6];
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			sum_s5[r] <= 72'(tp_s4[r][0]) + 72'(tp_s4[r][1]) + 72'(tp_s4[r][2])
				+ (72'(tr_s4[r]) <<< FRAC_BITS) + (72'sd1 <<< (FRAC_BITS-1));
			sum_s5[3+r] <= 72'(tp_s4[r][3]) + 72'(tp_s4[r][4]) + 72'(tp_s4[r][5])
				+ (72'sd1 <<< (FRAC_BITS-1));
		end
	end

	// stage 6: shift and saturate
	logic signed [31:0] res_s6 [6];
	always_ff @(posedge clk) begin
		for (int j = 0; j < 6; j++) begin
			res_s6[j] <= lbs_pkg::sat32(sum_s5[j] >>> FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], skin_in};
		end
	end

	// ---------------- output FIFO ----------------
	logic push;
	assign push = vld_q[LAT-1];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= res_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			inflight_q <= '0;
			wp_q       <= '0;
			rp_q       <= '0;
		end else begin
			cnt_q      <= cnt_q + ($bits(cnt_q))'(push) - ($bits(cnt_q))'(out_fire);
			inflight_q <= inflight_q + ($bits(inflight_q))'(skin_in)
				- ($bits(inflight_q))'(push);
			if (push) begin
				wp_q <= wp_q + ($bits(wp_q))'(1);
			end
			if (out_fire) begin
				rp_q <= rp_q + ($bits(rp_q))'(1);
			end
		end
	end

	assign out_pos_x = fifo_q[rp_q][0];
	assign out_pos_y = fifo_q[rp_q][1];
	assign out_pos_z = fifo_q[rp_q][2];
	assign out_nrm_x = fifo_q[rp_q][3];
	assign out_nrm_y = fifo_q[rp_q][4];
	assign out_nrm_z = fifo_q[rp_q][5];

endmodule
